FILE: rtl/pts_pkg.sv
`timescale 1ns / 1ps

package pts_pkg;

    localparam int MAX_TASKS  = 16;
    localparam int TIDX_W     = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int LEN_W      = $clog2(MAX_TASKS + 1);
    localparam int LIST_DEPTH = 2 ** TIDX_W;
    localparam int NUM_LISTS  = 5;
    localparam int LIST_W     = 3;

    localparam logic [1:0] MODE_RR  = 2'd0;
    localparam logic [1:0] MODE_SJF = 2'd1;
    localparam logic [1:0] MODE_MLQ = 2'd2;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    typedef enum logic [LIST_W-1:0] {
        L_WAIT  = 3'd0,
        L_READY = 3'd1,
        L_HIGH  = 3'd2,
        L_MED   = 3'd3,
        L_LOW   = 3'd4
    } list_id_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_WAKE,
        S_SJF,
        S_SHIFT,
        S_FILE,
        S_PICK,
        S_RUN
    } state_t;

    typedef struct packed {
        list_id_t            list;
        logic [TIDX_W-1:0]   slot;
    } list_rd_t;

    typedef struct packed {
        logic                en;
        list_id_t            list;
        logic [TIDX_W-1:0]   slot;
        logic [TIDX_W-1:0]   data;
    } list_wr_t;

endpackage

FILE: rtl/pts_lists.sv
`timescale 1ns / 1ps

module pts_lists
    import pts_pkg::*;
(
    input  logic              aclk,
    input  list_rd_t          rd,
    output logic [TIDX_W-1:0] rd_data,
    input  list_wr_t          wr
);

    logic [TIDX_W-1:0] lane [NUM_LISTS];

    for (genvar l = 0; l < NUM_LISTS; l++) begin : g_list
        logic [TIDX_W-1:0] slots [LIST_DEPTH];

        always_ff @(posedge aclk) begin
            if (wr.en && (wr.list == list_id_t'(LIST_W'(l)))) begin
                slots[wr.slot] <= wr.data;
            end
        end

        assign lane[l] = slots[rd.slot];
    end

    assign rd_data = lane[rd.list];

endmodule

FILE: rtl/periodic_task_scheduler.sv
`timescale 1ns / 1ps

// channel   | handshake          | payload
// request   | s_valid / s_ready  | s_cmd s_task_id s_task_period s_first_release
//           |                    | s_task_level s_task_budget
// result    | m_valid / m_ready  | m_kind m_load_ok m_cycle_number m_running_id m_is_idle
//           |                    | m_quanta_left m_task_done m_switch_count
// config    | apb psel/penable   | sched_mode at byte address 0
//
// a tick walks the waiting list, then in SJF mode scans the ready list and moves the shortest job
// to the head, or in multilevel mode files the ready list into the level lists and picks one.
// the length of these walks is set by the single list read port and one table read a cycle.
// reset (aresetn low, synchronous) empties all lists and clears counters; no clearing pass.
// a finished result waits in the output register; the next request is taken meanwhile,
// but its result step stalls until the output register is free.

module periodic_task_scheduler
    import pts_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_cmd,
    input  logic [7:0]  s_task_id,
    input  logic [15:0] s_task_period,
    input  logic [31:0] s_first_release,
    input  logic [15:0] s_task_level,
    input  logic [15:0] s_task_budget,

    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_kind,
    output logic        m_load_ok,
    output logic [31:0] m_cycle_number,
    output logic [7:0]  m_running_id,
    output logic        m_is_idle,
    output logic [15:0] m_quanta_left,
    output logic        m_task_done,
    output logic [31:0] m_switch_count,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_TASKS);
    localparam logic [LEN_W-1:0] LEN_ONE = LEN_W'(1);
    localparam logic [TIDX_W-1:0] IDX_ONE = TIDX_W'(1);

    state_t state_reg, state_next;
    logic [1:0] mode_reg;

    logic        cmd_reg;
    logic [7:0]  id_in_reg;
    logic [15:0] period_in_reg;
    logic [31:0] rel_in_reg;
    logic [15:0] lvl_in_reg;
    logic [15:0] bud_in_reg;

    logic [TIDX_W-1:0] head_reg [NUM_LISTS];
    logic [TIDX_W-1:0] head_next [NUM_LISTS];
    logic [LEN_W-1:0]  len_reg [NUM_LISTS];
    logic [LEN_W-1:0]  len_next [NUM_LISTS];

    logic [LEN_W-1:0]  used_reg, used_next;
    logic [31:0]       os_reg, os_next;
    logic [7:0]        last_reg, last_next;
    logic [31:0]       sw_reg, sw_next;

    logic [LEN_W-1:0]  i_reg, i_next;
    logic [LEN_W-1:0]  k_reg, k_next;
    logic [LEN_W-1:0]  n_reg, n_next;
    logic [TIDX_W-1:0] best_reg, best_next;
    logic [15:0]       best_left_reg, best_left_next;
    logic [TIDX_W-1:0] best_e_reg, best_e_next;

    logic        m_valid_reg, m_valid_next;
    logic        kind_reg, kind_next;
    logic        ok_reg, ok_next;
    logic [31:0] cyc_reg, cyc_next;
    logic [7:0]  run_reg, run_next;
    logic        idle_reg, idle_next;
    logic [15:0] ql_reg, ql_next;
    logic        done_reg, done_next;
    logic [31:0] swo_reg, swo_next;

    // task tables
    logic [7:0]  id_tab      [MAX_TASKS];
    logic [15:0] period_tab  [MAX_TASKS];
    logic [31:0] release_tab [MAX_TASKS];
    logic [15:0] level_tab   [MAX_TASKS];
    logic [15:0] budget_tab  [MAX_TASKS];
    logic [15:0] left_tab    [MAX_TASKS];

    logic [TIDX_W-1:0] tab_idx;
    logic        tw_load;
    logic        tw_left;
    logic [15:0] tw_left_val;
    logic        tw_level;
    logic [15:0] tw_level_val;
    logic        tw_rel;
    logic [31:0] tw_rel_val;

    list_rd_t          lrd;
    list_wr_t          lwr;
    logic [TIDX_W-1:0] lrd_data;

    logic s_acc;
    logic out_free;
    logic cfg_wr;

    pts_lists u_lists (
        .aclk    (aclk),
        .rd      (lrd),
        .rd_data (lrd_data),
        .wr      (lwr)
    );

    assign s_ready  = (state_reg == S_IDLE);
    assign s_acc    = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite && (paddr[2] == 1'b0);
    assign prdata   = (paddr[2] == 1'b0) ? {30'd0, mode_reg} : 32'd0;

    assign m_valid        = m_valid_reg;
    assign m_kind         = kind_reg;
    assign m_load_ok      = ok_reg;
    assign m_cycle_number = cyc_reg;
    assign m_running_id   = run_reg;
    assign m_is_idle      = idle_reg;
    assign m_quanta_left  = ql_reg;
    assign m_task_done    = done_reg;
    assign m_switch_count = swo_reg;

    always_comb begin
        logic [TIDX_W-1:0] e;
        logic [15:0]       lv;
        logic [15:0]       left;
        logic [15:0]       nl;
        logic [7:0]        tid;
        list_id_t          tl;
        logic              front;
        logic [TIDX_W-1:0] h;

        state_next     = state_reg;
        for (int l = 0; l < NUM_LISTS; l++) begin
            head_next[l] = head_reg[l];
            len_next[l]  = len_reg[l];
        end
        used_next      = used_reg;
        os_next        = os_reg;
        last_next      = last_reg;
        sw_next        = sw_reg;
        i_next         = i_reg;
        k_next         = k_reg;
        n_next         = n_reg;
        best_next      = best_reg;
        best_left_next = best_left_reg;
        best_e_next    = best_e_reg;

        m_valid_next = m_valid_reg && !m_ready;
        kind_next    = kind_reg;
        ok_next      = ok_reg;
        cyc_next     = cyc_reg;
        run_next     = run_reg;
        idle_next    = idle_reg;
        ql_next      = ql_reg;
        done_next    = done_reg;
        swo_next     = swo_reg;

        tab_idx      = lrd_data;
        tw_load      = 1'b0;
        tw_left      = 1'b0;
        tw_left_val  = 16'd0;
        tw_level     = 1'b0;
        tw_level_val = 16'd0;
        tw_rel       = 1'b0;
        tw_rel_val   = 32'd0;

        lrd.list = L_READY;
        lrd.slot = head_reg[L_READY];
        lwr.en   = 1'b0;
        lwr.list = L_WAIT;
        lwr.slot = '0;
        lwr.data = '0;

        e     = lrd_data;
        lv    = 16'd0;
        left  = 16'd0;
        nl    = 16'd0;
        tid   = 8'd0;
        tl    = L_LOW;
        front = 1'b0;
        h     = '0;

        unique case (state_reg)
            S_IDLE: begin
                if (s_acc) begin
                    i_next     = '0;
                    k_next     = '0;
                    n_next     = len_reg[L_WAIT];
                    state_next = (s_cmd == CMD_TICK) ? S_WAKE : S_LOAD;
                end
            end

            S_LOAD: begin
                if (out_free) begin
                    ok_next = 1'b0;
                    if (used_reg < LEN_MAX) begin
                        tab_idx  = used_reg[TIDX_W-1:0];
                        tw_load  = 1'b1;
                        lwr.en   = 1'b1;
                        lwr.list = L_WAIT;
                        lwr.slot = head_reg[L_WAIT] + len_reg[L_WAIT][TIDX_W-1:0];
                        lwr.data = used_reg[TIDX_W-1:0];
                        len_next[L_WAIT] = len_reg[L_WAIT] + LEN_ONE;
                        used_next = used_reg + LEN_ONE;
                        ok_next   = 1'b1;
                    end
                    m_valid_next = 1'b1;
                    kind_next    = CMD_LOAD;
                    cyc_next     = os_reg;
                    run_next     = 8'd0;
                    idle_next    = 1'b0;
                    ql_next      = 16'd0;
                    done_next    = 1'b0;
                    swo_next     = sw_reg;
                    state_next   = S_IDLE;
                end
            end

            S_WAKE: begin
                if (i_reg < n_reg) begin
                    lrd.list = L_WAIT;
                    lrd.slot = head_reg[L_WAIT] + i_reg[TIDX_W-1:0];
                    tab_idx  = e;
                    if (os_reg >= release_tab[tab_idx]) begin
                        if (len_reg[L_READY] < LEN_MAX) begin
                            lwr.en   = 1'b1;
                            lwr.list = L_READY;
                            lwr.slot = head_reg[L_READY] + len_reg[L_READY][TIDX_W-1:0];
                            lwr.data = e;
                            len_next[L_READY] = len_reg[L_READY] + LEN_ONE;
                        end
                    end else begin
                        lwr.en   = 1'b1;
                        lwr.list = L_WAIT;
                        lwr.slot = head_reg[L_WAIT] + k_reg[TIDX_W-1:0];
                        lwr.data = e;
                        k_next   = k_reg + LEN_ONE;
                    end
                    i_next = i_reg + LEN_ONE;
                end else begin
                    len_next[L_WAIT] = k_reg;
                    i_next = '0;
                    n_next = len_reg[L_READY];
                    priority if (mode_reg == MODE_RR) begin
                        state_next = S_RUN;
                    end else if (mode_reg == MODE_SJF) begin
                        state_next = (len_reg[L_READY] == '0) ? S_RUN : S_SJF;
                    end else begin
                        state_next = S_FILE;
                    end
                end
            end

            S_SJF: begin
                if (i_reg < n_reg) begin
                    lrd.list = L_READY;
                    lrd.slot = head_reg[L_READY] + i_reg[TIDX_W-1:0];
                    tab_idx  = e;
                    left     = left_tab[tab_idx];
                    if ((i_reg == '0) || (left < best_left_reg)) begin
                        best_next      = i_reg[TIDX_W-1:0];
                        best_left_next = left;
                        best_e_next    = e;
                    end
                    i_next = i_reg + LEN_ONE;
                end else begin
                    state_next = S_SHIFT;
                end
            end

            S_SHIFT: begin
                // move the prefix back one place, then put the shortest job at the head
                if (best_reg != '0) begin
                    lrd.list  = L_READY;
                    lrd.slot  = head_reg[L_READY] + best_reg - IDX_ONE;
                    lwr.en    = 1'b1;
                    lwr.list  = L_READY;
                    lwr.slot  = head_reg[L_READY] + best_reg;
                    lwr.data  = lrd_data;
                    best_next = best_reg - IDX_ONE;
                end else begin
                    lwr.en     = 1'b1;
                    lwr.list   = L_READY;
                    lwr.slot   = head_reg[L_READY];
                    lwr.data   = best_e_reg;
                    state_next = S_RUN;
                end
            end

            S_FILE: begin
                if (i_reg < n_reg) begin
                    lrd.list = L_READY;
                    lrd.slot = head_reg[L_READY] + i_reg[TIDX_W-1:0];
                    tab_idx  = e;
                    lv       = level_tab[tab_idx];
                    priority if (lv == 16'd1) begin
                        tl = L_HIGH; front = 1'b0;
                    end else if (lv == 16'd2) begin
                        tl = L_MED;  front = 1'b0;
                    end else if (lv == 16'd3) begin
                        tl = L_MED;  front = 1'b1;
                    end else if (lv[1:0] == 2'd0) begin
                        tl = L_LOW;  front = 1'b0;
                    end else begin
                        tl = L_LOW;  front = 1'b1;
                    end
                    if (len_reg[tl] < LEN_MAX) begin
                        if (front) begin
                            h = head_reg[tl] - IDX_ONE;
                            head_next[tl] = h;
                        end else begin
                            h = head_reg[tl] + len_reg[tl][TIDX_W-1:0];
                        end
                        lwr.en   = 1'b1;
                        lwr.list = tl;
                        lwr.slot = h;
                        lwr.data = e;
                        len_next[tl] = len_reg[tl] + LEN_ONE;
                    end
                    i_next = i_reg + LEN_ONE;
                end else begin
                    len_next[L_READY] = '0;
                    state_next = S_PICK;
                end
            end

            S_PICK: begin
                priority if (len_reg[L_HIGH] != '0) begin
                    tl = L_HIGH;
                end else if (len_reg[L_MED] != '0) begin
                    tl = L_MED;
                end else begin
                    tl = L_LOW;
                end
                if (len_reg[tl] != '0) begin
                    lrd.list      = tl;
                    lrd.slot      = head_reg[tl];
                    head_next[tl] = head_reg[tl] + IDX_ONE;
                    len_next[tl]  = len_reg[tl] - LEN_ONE;
                    lwr.en        = 1'b1;
                    lwr.list      = L_READY;
                    lwr.slot      = head_reg[L_READY];
                    lwr.data      = lrd_data;
                    len_next[L_READY] = LEN_ONE;
                end
                state_next = S_RUN;
            end

            S_RUN: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    kind_next    = CMD_TICK;
                    ok_next      = 1'b0;
                    cyc_next     = os_reg;
                    run_next     = 8'd0;
                    idle_next    = 1'b0;
                    ql_next      = 16'd0;
                    done_next    = 1'b0;
                    if (len_reg[L_READY] == '0) begin
                        idle_next = 1'b1;
                        if (last_reg != 8'd0) begin
                            sw_next   = sw_reg + 32'd1;
                            last_next = 8'd0;
                        end
                        swo_next = (last_reg != 8'd0) ? sw_reg + 32'd1 : sw_reg;
                    end else begin
                        lrd.list = L_READY;
                        lrd.slot = head_reg[L_READY];
                        tab_idx  = e;
                        tid      = id_tab[tab_idx];
                        left     = left_tab[tab_idx];
                        if (tid != last_reg) begin
                            sw_next   = sw_reg + 32'd1;
                            last_next = tid;
                        end
                        swo_next = (tid != last_reg) ? sw_reg + 32'd1 : sw_reg;
                        nl       = (left != 16'd0) ? left - 16'd1 : 16'd0;
                        run_next = tid;
                        if (nl != 16'd0) begin
                            tw_left     = 1'b1;
                            tw_left_val = nl;
                            ql_next     = nl;
                            if (mode_reg == MODE_RR) begin
                                // rotate head to tail
                                lwr.en   = 1'b1;
                                lwr.list = L_READY;
                                lwr.slot = head_reg[L_READY] + len_reg[L_READY][TIDX_W-1:0];
                                lwr.data = e;
                                head_next[L_READY] = head_reg[L_READY] + IDX_ONE;
                            end else if (mode_reg != MODE_SJF) begin
                                tw_level     = 1'b1;
                                tw_level_val = level_tab[tab_idx] + 16'd1;
                            end
                        end else begin
                            tw_rel      = 1'b1;
                            tw_rel_val  = release_tab[tab_idx] + {16'd0, period_tab[tab_idx]};
                            tw_left     = 1'b1;
                            tw_left_val = budget_tab[tab_idx];
                            done_next   = 1'b1;
                            head_next[L_READY] = head_reg[L_READY] + IDX_ONE;
                            len_next[L_READY]  = len_reg[L_READY] - LEN_ONE;
                            if (len_reg[L_WAIT] < LEN_MAX) begin
                                lwr.en   = 1'b1;
                                lwr.list = L_WAIT;
                                lwr.slot = head_reg[L_WAIT] + len_reg[L_WAIT][TIDX_W-1:0];
                                lwr.data = e;
                                len_next[L_WAIT] = len_reg[L_WAIT] + LEN_ONE;
                            end
                        end
                    end
                    os_next    = os_reg + 32'd1;
                    state_next = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            mode_reg    <= MODE_MLQ;
            for (int l = 0; l < NUM_LISTS; l++) begin
                head_reg[l] <= '0;
                len_reg[l]  <= '0;
            end
            used_reg    <= '0;
            os_reg      <= '0;
            last_reg    <= '0;
            sw_reg      <= '0;
            i_reg       <= '0;
            k_reg       <= '0;
            n_reg       <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            if (cfg_wr) begin
                mode_reg <= pwdata[1:0];
            end
            for (int l = 0; l < NUM_LISTS; l++) begin
                head_reg[l] <= head_next[l];
                len_reg[l]  <= len_next[l];
            end
            used_reg    <= used_next;
            os_reg      <= os_next;
            last_reg    <= last_next;
            sw_reg      <= sw_next;
            i_reg       <= i_next;
            k_reg       <= k_next;
            n_reg       <= n_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            cmd_reg       <= s_cmd;
            id_in_reg     <= s_task_id;
            period_in_reg <= s_task_period;
            rel_in_reg    <= s_first_release;
            lvl_in_reg    <= s_task_level;
            bud_in_reg    <= s_task_budget;
        end
        best_reg      <= best_next;
        best_left_reg <= best_left_next;
        best_e_reg    <= best_e_next;
        kind_reg      <= kind_next;
        ok_reg        <= ok_next;
        cyc_reg       <= cyc_next;
        run_reg       <= run_next;
        idle_reg      <= idle_next;
        ql_reg        <= ql_next;
        done_reg      <= done_next;
        swo_reg       <= swo_next;
    end

    always_ff @(posedge aclk) begin
        if (tw_load && (cmd_reg == CMD_LOAD)) begin
            id_tab[tab_idx]      <= id_in_reg;
            period_tab[tab_idx]  <= period_in_reg;
            release_tab[tab_idx] <= rel_in_reg;
            level_tab[tab_idx]   <= lvl_in_reg;
            budget_tab[tab_idx]  <= bud_in_reg;
            left_tab[tab_idx]    <= bud_in_reg;
        end
        if (tw_left) begin
            left_tab[tab_idx] <= tw_left_val;
        end
        if (tw_level) begin
            level_tab[tab_idx] <= tw_level_val;
        end
        if (tw_rel) begin
            release_tab[tab_idx] <= tw_rel_val;
        end
    end

endmodule
